### hdl/mift_pkg.sv
// Package with the shared types and constants of the masked IPv4 filter table.
package mift_pkg;

    localparam int TableDepth = 1024;
    localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam int SlotW      = 10;
    localparam int WordW      = 32;
    localparam int ActW       = 2;
    localparam int StatW      = 2;

    localparam logic [ActW-1:0] ActLookup = 2'd0;
    localparam logic [ActW-1:0] ActAdd    = 2'd1;
    localparam logic [ActW-1:0] ActRemove = 2'd2;
    localparam logic [ActW-1:0] ActIgnore = 2'd3;

    localparam logic [StatW-1:0] StatOk       = 2'd0;
    localparam logic [StatW-1:0] StatFull     = 2'd1;
    localparam logic [StatW-1:0] StatNotFound = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic             vld;
        logic [WordW-1:0] mask;
        logic [WordW-1:0] value;
    } t_entry;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic             blocked;
        logic             matched;
        logic [SlotW-1:0] slot;
    } t_result;

endpackage

### hdl/mift_in_if.sv
// Request channel interface of the masked IPv4 filter table.
interface mift_in_if;
    logic                         valid;
    logic                         ready;
    logic [mift_pkg::ActW-1:0]    action;
    logic [mift_pkg::WordW-1:0]   addr;
    logic [mift_pkg::WordW-1:0]   entry_mask;
    logic [mift_pkg::WordW-1:0]   entry_value;

    modport source (output valid, output action, output addr, output entry_mask,
                    output entry_value, input ready);
    modport sink (input valid, input action, input addr, input entry_mask,
                  input entry_value, output ready);
endinterface

### hdl/mift_out_if.sv
// Result channel interface of the masked IPv4 filter table.
interface mift_out_if;
    logic                         valid;
    logic                         ready;
    logic [mift_pkg::StatW-1:0]   status;
    logic                         blocked;
    logic                         matched;
    logic [mift_pkg::SlotW-1:0]   slot;

    modport source (output valid, output status, output blocked, output matched,
                    output slot, input ready);
    modport sink (input valid, input status, input blocked, input matched,
                  input slot, output ready);
endinterface

### hdl/mift_ram.sv
// Entry memory with one write port and one registered read port.
module mift_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [mift_pkg::IdxW-1:0]  i_waddr,
    input  mift_pkg::t_entry           i_wdata,
    input  logic                       i_re,
    input  logic [mift_pkg::IdxW-1:0]  i_raddr,
    output mift_pkg::t_entry           o_rdata
);

    mift_pkg::t_entry r_mem [mift_pkg::TableDepth];
    mift_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mift_ctrl.sv
// Sequencer that clears the table after reset and scans it once per lookup, add or remove transaction.
module mift_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mift_in_if.sink                    i_req,
    input  logic                       i_ban_mode,
    input  logic                       i_out_free,
    output logic                       o_done,
    output mift_pkg::t_result          o_res,
    output logic                       o_ram_we,
    output logic [mift_pkg::IdxW-1:0]  o_ram_waddr,
    output mift_pkg::t_entry           o_ram_wdata,
    output logic                       o_ram_re,
    output logic [mift_pkg::IdxW-1:0]  o_ram_raddr,
    input  mift_pkg::t_entry           i_ram_rdata
);

    localparam logic [mift_pkg::IdxW-1:0] LastIdx = mift_pkg::IdxW'(mift_pkg::TableDepth - 1);

    mift_pkg::t_state                r_state, n_state;
    logic [mift_pkg::IdxW-1:0]       r_idx, n_idx;
    logic                            r_issue, n_issue;
    logic                            r_chk, n_chk;
    logic [mift_pkg::IdxW-1:0]       r_chk_idx, n_chk_idx;
    logic                            r_chk_last, n_chk_last;
    logic [mift_pkg::ActW-1:0]       r_act, n_act;
    logic [mift_pkg::WordW-1:0]      r_addr, n_addr;
    logic [mift_pkg::WordW-1:0]      r_mask, n_mask;
    logic [mift_pkg::WordW-1:0]      r_value, n_value;
    mift_pkg::t_result               r_res, n_res;
    logic                            hit;
    logic                            ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mift_pkg::S_CLEAR;
            r_idx   <= '0;
            r_issue <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_issue <= n_issue;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_chk_last <= n_chk_last;
        r_act      <= n_act;
        r_addr     <= n_addr;
        r_mask     <= n_mask;
        r_value    <= n_value;
        r_res      <= n_res;
    end

    always_comb begin
        case (r_act)
            mift_pkg::ActLookup: hit = i_ram_rdata.vld &&
                                       ((r_addr & i_ram_rdata.mask) == i_ram_rdata.value);
            mift_pkg::ActAdd:    hit = !i_ram_rdata.vld;
            mift_pkg::ActRemove: hit = i_ram_rdata.vld && (i_ram_rdata.mask == r_mask) &&
                                       (i_ram_rdata.value == r_value);
            default:             hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_chk_last  = r_chk_last;
        n_act       = r_act;
        n_addr      = r_addr;
        n_mask      = r_mask;
        n_value     = r_value;
        n_res       = r_res;
        ready       = 1'b0;
        o_done      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_chk_idx;
        o_ram_wdata = '{vld: 1'b0, mask: r_mask, value: r_value};
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx;

        case (r_state)
            mift_pkg::S_CLEAR: begin
                // Sweep the whole table once so every valid bit starts cleared.
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx;
                n_idx       = r_idx + 1'b1;
                if (r_idx == LastIdx) begin
                    n_idx   = '0;
                    n_state = mift_pkg::S_IDLE;
                end
            end
            mift_pkg::S_IDLE: begin
                ready = 1'b1;
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_addr  = i_req.addr;
                    n_mask  = i_req.entry_mask;
                    n_value = i_req.entry_value & i_req.entry_mask;
                    if (i_req.action inside {mift_pkg::ActLookup, mift_pkg::ActAdd,
                                             mift_pkg::ActRemove}) begin
                        n_state = mift_pkg::S_SCAN;
                        n_idx   = '0;
                        n_issue = 1'b1;
                        n_chk   = 1'b0;
                    end else begin
                        n_res   = '0;
                        n_state = mift_pkg::S_RESP;
                    end
                end
            end
            mift_pkg::S_SCAN: begin
                if (r_issue) begin
                    o_ram_re   = 1'b1;
                    n_chk      = 1'b1;
                    n_chk_idx  = r_idx;
                    n_chk_last = (r_idx == LastIdx);
                    n_idx      = r_idx + 1'b1;
                    if (r_idx == LastIdx) begin
                        n_issue = 1'b0;
                    end
                end else begin
                    n_chk = 1'b0;
                end

                if (r_chk) begin
                    if (hit) begin
                        n_res   = '0;
                        n_state = mift_pkg::S_RESP;
                        n_issue = 1'b0;
                        n_chk   = 1'b0;
                        if (r_act == mift_pkg::ActLookup) begin
                            n_res.matched = 1'b1;
                            n_res.blocked = i_ban_mode;
                        end else begin
                            n_res.status = mift_pkg::StatOk;
                            n_res.slot   = mift_pkg::SlotW'(r_chk_idx);
                            o_ram_we     = 1'b1;
                            o_ram_wdata.vld = (r_act == mift_pkg::ActAdd);
                        end
                    end else if (r_chk_last) begin
                        n_res   = '0;
                        n_state = mift_pkg::S_RESP;
                        n_chk   = 1'b0;
                        case (r_act)
                            mift_pkg::ActLookup: n_res.blocked = !i_ban_mode;
                            mift_pkg::ActAdd:    n_res.status  = mift_pkg::StatFull;
                            mift_pkg::ActRemove: n_res.status  = mift_pkg::StatNotFound;
                            default:             n_res         = '0;
                        endcase
                    end
                end
            end
            mift_pkg::S_RESP: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_state = mift_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mift_pkg::S_IDLE;
            end
        endcase
    end

    assign i_req.ready = ready;
    assign o_res       = r_res;

endmodule

### hdl/masked_ip_filter_table.sv
// Top level of the masked IPv4 filter table.
// The request channel i_req carries one transaction per command: action 0 looks
// up addr, action 1 adds the entry (entry_mask, entry_value), action 2 removes the
// first equal entry. Action 3 does nothing and returns an all-zero result.
// The result channel o_rsp returns exactly one transaction per request with
// status, blocked, matched and slot. i_cfg_we with i_cfg_wdata sets the ban mode.
// Each command scans the entry memory from slot 0 upward, one slot per cycle
// through its single read port, and stops at the first qualifying slot.
// One command is in work at a time, and the next request is accepted only after
// the result of the last one has been taken into the output register.
// After reset the ban mode is 1 and a clearing pass writes every slot invalid;
// no request is accepted during it.
// A result waits in an output register while the receiver stalls, and the next
// request is already accepted and scanned meanwhile; the scan holds its result
// until the output register is free.
module masked_ip_filter_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    mift_in_if.sink     i_req,
    mift_out_if.source  o_rsp
);

    logic                             r_ban_mode;
    logic                             r_o_valid;
    mift_pkg::t_result                r_o_res;
    logic                             out_free;
    logic                             done;
    mift_pkg::t_result                res;
    logic                             ram_we;
    logic [mift_pkg::IdxW-1:0]        ram_waddr;
    mift_pkg::t_entry                 ram_wdata;
    logic                             ram_re;
    logic [mift_pkg::IdxW-1:0]        ram_raddr;
    mift_pkg::t_entry                 ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ban_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_ban_mode <= i_cfg_wdata;
        end
    end

    assign out_free = !r_o_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && done) begin
            r_o_res <= res;
        end
    end

    mift_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_ban_mode  (r_ban_mode),
        .i_out_free  (out_free),
        .o_done      (done),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    mift_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_rsp.valid   = r_o_valid;
    assign o_rsp.status  = r_o_res.status;
    assign o_rsp.blocked = r_o_res.blocked;
    assign o_rsp.matched = r_o_res.matched;
    assign o_rsp.slot    = r_o_res.slot;

endmodule
